>>> design/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, codes and control types of the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int MAX_DIM    = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 7;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              acc_clr;
        logic              load_out;
        logic              load_oor;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_stat;

    // zero acts as one, anything above the store size acts as the store size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] reg_val);
        logic [DIM_W-1:0] res;
        if (reg_val == '0) begin
            res = DIM_W'(1);
        end else if (reg_val > DIM_MAX) begin
            res = DIM_MAX;
        end else begin
            res = reg_val;
        end
        return res;
    endfunction

endpackage

>>> design/integer_matrix_multiply_core.sv
// order: a write goes straight into its store; a product read walks the inner index,
//   drains the pipeline and loads the result register; an out-of-range read skips to the load
// throughput: one item at a time; the inner loop is one multiply-add per cycle,
//   bounded by the single read port of each element store
// reset: synchronous, active low; sizes return to 64, element stores are not cleared
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Signed integer matrix multiplier: element writes into A and B, product reads.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [imm_pkg::MODE_W-1:0]           i_mode,
    input  logic [imm_pkg::IDX_W-1:0]            i_row,
    input  logic [imm_pkg::IDX_W-1:0]            i_col,
    input  logic signed [imm_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [imm_pkg::DATA_WIDTH-1:0] o_product_value,
    output logic                                 o_out_of_range
);
    import imm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    imm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    imm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product_value (o_product_value),
        .o_out_of_range  (o_out_of_range)
    );

    // an out-of-range result always carries a zero value
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_product_value == '0))
        else $error("out-of-range result with nonzero value");

    // a read transaction keeps the input side closed on the next cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == MODE_READ)) |=> !o_in_ready)
        else $error("input accepted right after a read");

    // a new result is loaded only while no input transaction can be taken
    a_load_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out) |-> !o_in_ready)
        else $error("result loaded while input side open");

endmodule

>>> design/imm_datapath.sv
// ----------------------------------------------------------------------------
// imm_datapath
// Element stores for A and B, multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
module imm_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  imm_pkg::t_dp_cmd                     i_cmd,
    output imm_pkg::t_dp_stat                    o_stat,
    input  logic signed [imm_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [imm_pkg::DATA_WIDTH-1:0] o_product_value,
    output logic                                 o_out_of_range
);
    import imm_pkg::*;

    logic [DATA_WIDTH-1:0]   r_mem_a [DEPTH];
    logic [DATA_WIDTH-1:0]   r_mem_b [DEPTH];
    logic [DATA_WIDTH-1:0]   r_a_q;
    logic [DATA_WIDTH-1:0]   r_b_q;
    logic                    r_rd_vld;
    logic [DATA_WIDTH-1:0]   r_mul;
    logic                    r_mul_vld;
    logic [DATA_WIDTH-1:0]   r_acc;
    logic                    r_out_valid;
    logic [DATA_WIDTH-1:0]   r_out_data;
    logic                    r_out_oor;
    logic [DATA_WIDTH-1:0]   w_prod;

    // low half of the product is the same for signed and unsigned operands
    assign w_prod = r_a_q * r_b_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_cmd.wr_addr] <= $unsigned(i_value);
        end
        if (i_cmd.wr_b) begin
            r_mem_b[i_cmd.wr_addr] <= $unsigned(i_value);
        end
        if (i_cmd.rd_en) begin
            r_a_q <= r_mem_a[i_cmd.rd_addr_a];
            r_b_q <= r_mem_b[i_cmd.rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= w_prod;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + r_mul;
        end
        if (i_cmd.load_out) begin
            r_out_data <= i_cmd.load_oor ? '0 : r_acc;
            r_out_oor  <= i_cmd.load_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.rd_en;
            r_mul_vld <= r_rd_vld;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.busy     = r_rd_vld | r_mul_vld;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_product_value = $signed(r_out_data);
    assign o_out_of_range  = r_out_oor;

endmodule

>>> design/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Size registers, range checks and the sequencer that walks the inner index.
// ----------------------------------------------------------------------------
module imm_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [imm_pkg::MODE_W-1:0]      i_mode,
    input  logic [imm_pkg::IDX_W-1:0]       i_row,
    input  logic [imm_pkg::IDX_W-1:0]       i_col,
    output imm_pkg::t_dp_cmd                o_cmd,
    input  imm_pkg::t_dp_stat               i_stat
);
    import imm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_rows_a, n_rows_a;
    logic [DIM_W-1:0] r_inner, n_inner;
    logic [DIM_W-1:0] r_cols_b, n_cols_b;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_oor, n_oor;

    logic [DIM_W-1:0] w_nr, w_nk, w_nc;
    logic             w_accept;
    logic             w_a_ok, w_b_ok, w_rd_ok;
    logic             w_last;

    assign w_nr = eff_dim(r_rows_a);
    assign w_nk = eff_dim(r_inner);
    assign w_nc = eff_dim(r_cols_b);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_a_ok  = ({1'b0, i_row} < w_nr) && ({1'b0, i_col} < w_nk);
    assign w_b_ok  = ({1'b0, i_row} < w_nk) && ({1'b0, i_col} < w_nc);
    assign w_rd_ok = ({1'b0, i_row} < w_nr) && ({1'b0, i_col} < w_nc);
    assign w_last  = ({1'b0, r_k} == (w_nk - DIM_W'(1)));

    always_comb begin
        n_state  = r_state;
        n_rows_a = r_rows_a;
        n_inner  = r_inner;
        n_cols_b = r_cols_b;
        n_row    = r_row;
        n_col    = r_col;
        n_k      = r_k;
        n_oor    = r_oor;

        o_cmd           = '0;
        o_cmd.wr_addr   = {i_row, i_col};
        o_cmd.rd_addr_a = {r_row, r_k};
        o_cmd.rd_addr_b = {r_k, r_col};
        o_cmd.load_oor  = r_oor;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    n_rows_a = i_cfg_data;
                CFG_INNER_DIM: n_inner  = i_cfg_data;
                CFG_COLS_B:    n_cols_b = i_cfg_data;
                default:       ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        MODE_WR_A: o_cmd.wr_a = w_a_ok;
                        MODE_WR_B: o_cmd.wr_b = w_b_ok;
                        MODE_READ: begin
                            o_cmd.acc_clr = 1'b1;
                            n_row = i_row;
                            n_col = i_col;
                            n_k   = '0;
                            n_oor = !w_rd_ok;
                            n_state = w_rd_ok ? ST_RUN : ST_FINISH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.rd_en = 1'b1;
                n_k = r_k + IDX_W'(1);
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait until the last product has reached the accumulator
                if (!i_stat.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rows_a <= DIM_RESET;
            r_inner  <= DIM_RESET;
            r_cols_b <= DIM_RESET;
            r_oor    <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_rows_a <= n_rows_a;
            r_inner  <= n_inner;
            r_cols_b <= n_cols_b;
            r_oor    <= n_oor;
            r_k      <= n_k;
        end
        r_row <= n_row;
        r_col <= n_col;
    end

endmodule
